### src/puf_pkg.sv
// Shared types and constants for the persistent union-find block.
// No dependencies; every other file in src but puf_ram imports this package.
package puf_pkg;

  localparam int IDX_W          = 10;
  localparam int CNT_W          = 11;
  localparam int VER_OUT_W      = 11;
  localparam int RST_ELEM_COUNT = 1024;

  localparam logic CMD_UNITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] source_version;
    logic [IDX_W-1:0] elem_a;
    logic [IDX_W-1:0] elem_b;
  } puf_in_t;

  typedef struct packed {
    logic                 same_set;
    logic                 is_answer;
    logic [VER_OUT_W-1:0] version_written;
    logic                 out_of_room;
  } puf_out_t;

endpackage

### src/puf_if.sv
// Valid/ready channel interfaces for command words, result words and the
// element count register. Depends on puf_pkg.
interface puf_in_if import puf_pkg::*; ();
  logic    valid;
  logic    ready;
  puf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface puf_out_if import puf_pkg::*; ();
  logic     valid;
  logic     ready;
  puf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface puf_cfg_if import puf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] element_count;
  modport source (output valid, output element_count, input ready);
  modport sink (input valid, input element_count, output ready);
endinterface

### src/persistent_union_find.sv
// Versioned disjoint-set store: union by size, no path compression, each version
// held as a path-copied balanced tree in a node pool shared between versions.
// Depends on puf_pkg, puf_if and puf_ram.
//
// One command word is taken at a time. With n elements and D = ceil(log2 n), each
// element lookup walks the tree through the node memory read port: a read step and
// a wait step per tree level including the leaf, then one step to evaluate the entry.
// A lookup that stays in subtrees still equal to version zero skips the wait steps.
// A find follows up to D+1 parent links, so the two finds of a word take up to
// 2 * (D+1) lookups and far fewer on shallow sets. A union adds two path copies.
// Version zero is never stored: it is a marker pointer, so a write of element_count
// takes effect at once and there is no clearing pass. The next command word is
// accepted while the previous result word still waits.
module persistent_union_find import puf_pkg::*; #(
  parameter int ARRAY_SIZE = 1024,
  parameter int NODE_POOL  = 65536,
  parameter int VERSIONS   = 1024
) (
  input  logic clk,
  input  logic rst_n,
  puf_cfg_if.sink   cfg_ch,
  puf_in_if.sink    in_ch,
  puf_out_if.source out_ch
);

  localparam int CW      = $clog2(ARRAY_SIZE + 1);
  localparam int LW      = CW + 1;
  localparam int PW      = $clog2(NODE_POOL);
  localparam int NCW     = $clog2(NODE_POOL + 1);
  localparam int PTRW    = PW + 1;
  localparam int PF      = (PTRW > LW) ? PTRW : LW;
  localparam int NWW     = 2 * PF;
  localparam int VIW     = $clog2(VERSIONS);
  localparam int NVW     = $clog2(VERSIONS + 1);
  localparam int SD      = $clog2(ARRAY_SIZE);
  localparam int SIW     = (SD > 1) ? $clog2(SD) : 1;
  localparam int LVW     = $clog2(SD + 1);
  localparam int NDW     = $clog2(2 * (SD + 1) + 1);
  localparam int CAP     = (ARRAY_SIZE < (NODE_POOL + 1) / 2) ? ARRAY_SIZE
                                                              : (NODE_POOL + 1) / 2;
  localparam int RST_EFF = (CAP < RST_ELEM_COUNT) ? CAP : RST_ELEM_COUNT;
  localparam int RST_NEED = 2 * ($clog2(RST_EFF) + 1);

  localparam logic [PTRW-1:0] ZERO_PTR = {1'b1, {PW{1'b0}}};

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_VWAIT  = 12'b0000_0000_0010,
    S_RSTEP  = 12'b0000_0000_0100,
    S_RWAIT  = 12'b0000_0000_1000,
    S_FEVAL  = 12'b0000_0001_0000,
    S_DECIDE = 12'b0000_0010_0000,
    S_WSTEP  = 12'b0000_0100_0000,
    S_WWAIT  = 12'b0000_1000_0000,
    S_WLEAF  = 12'b0001_0000_0000,
    S_WUP    = 12'b0010_0000_0000,
    S_VWRITE = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  function automatic logic [NDW-1:0] need_of(input logic [CW-1:0] n);
    logic [CW-1:0] nm1;
    int            r;
    nm1 = n - 1'b1;
    r   = 0;
    for (int i = 0; i < CW; i++) begin
      if (nm1[i]) begin
        r = i + 1;
      end
    end
    return NDW'(2 * (r + 1));
  endfunction

  state_t state_r, state_nxt;
  logic   cmd_r, cmd_nxt;
  logic [CW-1:0] b_r, b_nxt, cur_r, cur_nxt;
  logic [CW-1:0] ra_r, ra_nxt, rb_r, rb_nxt, keep_r, keep_nxt, link_r, link_nxt;
  logic signed [LW-1:0] sa_r, sa_nxt, sb_r, sb_nxt, leaf_r, leaf_nxt, wval_r, wval_nxt;
  logic          find_b_r, find_b_nxt, wphase_r, wphase_nxt;
  logic [PTRW-1:0] root_r, root_nxt, wptr_r, wptr_nxt, newp_r, newp_nxt;
  logic [CW-1:0] wlen_r, wlen_nxt, widx_r, widx_nxt;
  logic [LVW-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0] eff_r, eff_nxt;
  logic [NCW-1:0] ncnt_r, ncnt_nxt;
  logic [NDW-1:0] need_r, need_nxt;
  logic [NVW-1:0] nver_r, nver_nxt;
  puf_out_t res_r, res_nxt, out_data_r, out_data_nxt;
  logic     out_valid_r, out_valid_nxt;

  logic            stk_dir_r [SD];
  logic [PTRW-1:0] stk_sib_r [SD];
  logic            push_en, push_dir;
  logic [PTRW-1:0] push_sib;
  logic [SIW-1:0]  pop_idx;

  logic            nm_we;
  logic [NWW-1:0]  nm_wdata, nm_rdata;
  logic            vm_we;
  logic [VIW-1:0]  vm_raddr;
  logic [PTRW-1:0] vm_rdata;

  logic [CW-1:0]   half, len_ch, idx_ch, a_c, b_c, eff_new;
  logic            go_right, is_leaf, found, load_out;
  logic [PTRW-1:0] rd_left, rd_right;
  logic signed [LW-1:0] rd_leaf;
  logic [31:0]     src_c;
  logic [NCW-1:0]  room;

  assign half     = wlen_r >> 1;
  assign go_right = (widx_r >= half);
  assign len_ch   = go_right ? (wlen_r - half) : half;
  assign idx_ch   = go_right ? (widx_r - half) : widx_r;
  assign is_leaf  = (wlen_r <= CW'(1));
  assign rd_left  = nm_rdata[PF +: PTRW];
  assign rd_right = nm_rdata[0 +: PTRW];
  assign rd_leaf  = nm_rdata[PF +: LW];
  assign pop_idx  = SIW'(lvl_r - 1'b1);
  assign found    = leaf_r[LW-1] || (leaf_r[CW-1:0] >= eff_r);
  assign room     = NCW'(NODE_POOL) - ncnt_r;
  assign load_out = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    a_c = (32'(in_ch.data.elem_a) >= 32'(eff_r)) ? (eff_r - 1'b1) : CW'(in_ch.data.elem_a);
    b_c = (32'(in_ch.data.elem_b) >= 32'(eff_r)) ? (eff_r - 1'b1) : CW'(in_ch.data.elem_b);
    src_c = (32'(in_ch.data.source_version) >= 32'(nver_r)) ? 32'd0
                                                             : 32'(in_ch.data.source_version);
    vm_raddr = VIW'(src_c);
    if (cfg_ch.element_count == '0) begin
      eff_new = CW'(1);
    end else if (32'(cfg_ch.element_count) > CAP) begin
      eff_new = CW'(CAP);
    end else begin
      eff_new = CW'(cfg_ch.element_count);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    b_nxt      = b_r;
    cur_nxt    = cur_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    sa_nxt     = sa_r;
    sb_nxt     = sb_r;
    keep_nxt   = keep_r;
    link_nxt   = link_r;
    leaf_nxt   = leaf_r;
    wval_nxt   = wval_r;
    find_b_nxt = find_b_r;
    wphase_nxt = wphase_r;
    root_nxt   = root_r;
    wptr_nxt   = wptr_r;
    newp_nxt   = newp_r;
    wlen_nxt   = wlen_r;
    widx_nxt   = widx_r;
    lvl_nxt    = lvl_r;
    eff_nxt    = eff_r;
    ncnt_nxt   = ncnt_r;
    need_nxt   = need_r;
    nver_nxt   = nver_r;
    res_nxt    = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    push_en  = 1'b0;
    push_dir = go_right;
    push_sib = ZERO_PTR;
    nm_we    = 1'b0;
    nm_wdata = '0;
    vm_we    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cfg_ch.valid) begin
          eff_nxt  = eff_new;
          ncnt_nxt = NCW'({eff_new, 1'b0} - 1'b1);
          need_nxt = need_of(eff_new);
          nver_nxt = NVW'(1);
        end else if (in_ch.valid) begin
          res_nxt = '0;
          if (nver_r >= NVW'(VERSIONS)) begin
            res_nxt.out_of_room = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd_nxt    = in_ch.data.command;
            b_nxt      = b_c;
            cur_nxt    = a_c;
            find_b_nxt = 1'b0;
            wlen_nxt   = eff_r;
            widx_nxt   = a_c;
            if (src_c == 32'd0) begin
              root_nxt  = ZERO_PTR;
              wptr_nxt  = ZERO_PTR;
              state_nxt = S_RSTEP;
            end else begin
              state_nxt = S_VWAIT;
            end
          end
        end
      end
      S_VWAIT: begin
        root_nxt  = vm_rdata;
        wptr_nxt  = vm_rdata;
        state_nxt = S_RSTEP;
      end
      S_RSTEP: begin
        if (wptr_r[PW]) begin
          if (is_leaf) begin
            leaf_nxt  = -LW'(1);
            state_nxt = S_FEVAL;
          end else begin
            wlen_nxt = len_ch;
            widx_nxt = idx_ch;
          end
        end else begin
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (is_leaf) begin
          leaf_nxt  = rd_leaf;
          state_nxt = S_FEVAL;
        end else begin
          wptr_nxt  = go_right ? rd_right : rd_left;
          wlen_nxt  = len_ch;
          widx_nxt  = idx_ch;
          state_nxt = S_RSTEP;
        end
      end
      S_FEVAL: begin
        wptr_nxt  = root_r;
        wlen_nxt  = eff_r;
        state_nxt = S_RSTEP;
        if (found) begin
          if (!find_b_r) begin
            ra_nxt     = cur_r;
            sa_nxt     = leaf_r;
            find_b_nxt = 1'b1;
            cur_nxt    = b_r;
            widx_nxt   = b_r;
          end else begin
            rb_nxt    = cur_r;
            sb_nxt    = leaf_r;
            state_nxt = S_DECIDE;
          end
        end else begin
          cur_nxt  = leaf_r[CW-1:0];
          widx_nxt = leaf_r[CW-1:0];
        end
      end
      S_DECIDE: begin
        newp_nxt = root_r;
        if (cmd_r == CMD_QUERY) begin
          res_nxt.same_set  = (ra_r == rb_r);
          res_nxt.is_answer = 1'b1;
          state_nxt = S_VWRITE;
        end else if (ra_r == rb_r) begin
          state_nxt = S_VWRITE;
        end else if (room < NCW'(need_r)) begin
          res_nxt.out_of_room = 1'b1;
          state_nxt = S_OUT;
        end else begin
          keep_nxt   = (sa_r > sb_r) ? rb_r : ra_r;
          link_nxt   = (sa_r > sb_r) ? ra_r : rb_r;
          widx_nxt   = (sa_r > sb_r) ? rb_r : ra_r;
          wval_nxt   = LW'(sa_r + sb_r);
          wptr_nxt   = root_r;
          wlen_nxt   = eff_r;
          lvl_nxt    = '0;
          wphase_nxt = 1'b0;
          state_nxt  = S_WSTEP;
        end
      end
      S_WSTEP: begin
        if (is_leaf) begin
          state_nxt = S_WLEAF;
        end else if (wptr_r[PW]) begin
          push_en  = 1'b1;
          wlen_nxt = len_ch;
          widx_nxt = idx_ch;
          lvl_nxt  = lvl_r + 1'b1;
        end else begin
          state_nxt = S_WWAIT;
        end
      end
      S_WWAIT: begin
        push_en   = 1'b1;
        push_sib  = go_right ? rd_left : rd_right;
        wptr_nxt  = go_right ? rd_right : rd_left;
        wlen_nxt  = len_ch;
        widx_nxt  = idx_ch;
        lvl_nxt   = lvl_r + 1'b1;
        state_nxt = S_WSTEP;
      end
      S_WLEAF: begin
        nm_we     = 1'b1;
        nm_wdata  = {PF'(wval_r), PF'(wval_r)};
        newp_nxt  = {1'b0, ncnt_r[PW-1:0]};
        ncnt_nxt  = ncnt_r + 1'b1;
        state_nxt = S_WUP;
      end
      S_WUP: begin
        if (lvl_r == '0) begin
          if (!wphase_r) begin
            wphase_nxt = 1'b1;
            wval_nxt   = LW'(keep_r);
            wptr_nxt   = newp_r;
            widx_nxt   = link_r;
            wlen_nxt   = eff_r;
            state_nxt  = S_WSTEP;
          end else begin
            state_nxt = S_VWRITE;
          end
        end else begin
          nm_we    = 1'b1;
          nm_wdata = stk_dir_r[pop_idx] ? {PF'(stk_sib_r[pop_idx]), PF'(newp_r)}
                                        : {PF'(newp_r), PF'(stk_sib_r[pop_idx])};
          newp_nxt = {1'b0, ncnt_r[PW-1:0]};
          ncnt_nxt = ncnt_r + 1'b1;
          lvl_nxt  = lvl_r - 1'b1;
        end
      end
      S_VWRITE: begin
        vm_we = 1'b1;
        res_nxt.version_written = VER_OUT_W'(nver_r);
        nver_nxt  = nver_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      eff_r       <= CW'(RST_EFF);
      ncnt_r      <= NCW'(2 * RST_EFF - 1);
      need_r      <= NDW'(RST_NEED);
      nver_r      <= NVW'(1);
      lvl_r       <= '0;
      find_b_r    <= 1'b0;
      wphase_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      eff_r       <= eff_nxt;
      ncnt_r      <= ncnt_nxt;
      need_r      <= need_nxt;
      nver_r      <= nver_nxt;
      lvl_r       <= lvl_nxt;
      find_b_r    <= find_b_nxt;
      wphase_r    <= wphase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    b_r        <= b_nxt;
    cur_r      <= cur_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    keep_r     <= keep_nxt;
    link_r     <= link_nxt;
    leaf_r     <= leaf_nxt;
    wval_r     <= wval_nxt;
    root_r     <= root_nxt;
    wptr_r     <= wptr_nxt;
    newp_r     <= newp_nxt;
    wlen_r     <= wlen_nxt;
    widx_r     <= widx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (push_en) begin
      stk_dir_r[lvl_r[SIW-1:0]] <= push_dir;
      stk_sib_r[lvl_r[SIW-1:0]] <= push_sib;
    end
  end

  puf_ram #(.DEPTH(NODE_POOL), .WIDTH(NWW)) u_node_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (ncnt_r[PW-1:0]),
    .wdata (nm_wdata),
    .raddr (wptr_r[PW-1:0]),
    .rdata (nm_rdata)
  );

  puf_ram #(.DEPTH(VERSIONS), .WIDTH(PTRW)) u_ver_ram (
    .clk   (clk),
    .we    (vm_we),
    .waddr (nver_r[VIW-1:0]),
    .wdata (newp_r),
    .raddr (vm_raddr),
    .rdata (vm_rdata)
  );

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ncnt_r <= NCW'(NODE_POOL))
    else $error("node count beyond pool size");

  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WLEAF || state_r == S_WUP) && nm_we |-> ncnt_r < NCW'(NODE_POOL))
    else $error("node allocated with pool full");

  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.out_of_room |->
      !out_ch.data.is_answer && !out_ch.data.same_set && out_ch.data.version_written == '0)
    else $error("overflow word carries other fields");

  a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LVW'(SD))
    else $error("path stack overflow");

endmodule

### src/puf_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the node pool and the version root table. No dependencies.
module puf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### test/persistent_union_find_tb.sv
// Self-checking testbench for persistent_union_find: drives command words with random
// gaps, stalls the result channel and predicts every result word from a versioned model.
// Depends on puf_pkg, puf_if and the RTL under src.
module persistent_union_find_tb import puf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_VER   = 1024;
  localparam int N_ELEM  = 1024;
  localparam int IDLE_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  puf_cfg_if cfg_ch();
  puf_in_if  in_ch();
  puf_out_if out_ch();

  persistent_union_find uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch.sink),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #6 clk = ~clk;

  // Shadow of every version: negative entries are roots holding minus the set size.
  int       parent_of [0:N_VER-1][0:N_ELEM-1];
  int       live_count;
  int       next_ver;
  puf_in_t  cmd_q[$];
  puf_out_t result_q[$];
  int       mismatches = 0;
  int       gen_ver;
  int       gen_count;

  function automatic int root_of(int v, int a);
    int p;
    for (int g = 0; g <= live_count; g++) begin
      p = parent_of[v][a];
      if (p < 0 || p >= live_count) return a;
      a = p;
    end
    return a;
  endfunction

  function automatic void load_count(logic [CNT_W-1:0] value);
    int n;
    n = value;
    if (n < 1) n = 1;
    if (n > N_ELEM) n = N_ELEM;
    live_count = n;
    for (int i = 0; i < N_ELEM; i++) parent_of[0][i] = -1;
    next_ver = 1;
  endfunction

  function automatic puf_out_t apply_word(puf_in_t w);
    puf_out_t r;
    int src, a, b, ra, rb, sa, sb, keep, link;
    r = '0;
    if (next_ver >= N_VER) begin
      r.out_of_room = 1'b1;
      return r;
    end
    src = w.source_version;
    a = w.elem_a;
    b = w.elem_b;
    if (src >= next_ver) src = 0;
    if (a >= live_count) a = live_count - 1;
    if (b >= live_count) b = live_count - 1;
    ra = root_of(src, a);
    rb = root_of(src, b);
    for (int i = 0; i < N_ELEM; i++) parent_of[next_ver][i] = parent_of[src][i];
    if (w.command == CMD_QUERY) begin
      r.same_set = (ra == rb);
      r.is_answer = 1'b1;
    end else if (ra != rb) begin
      sa = parent_of[src][ra];
      sb = parent_of[src][rb];
      keep = ra;
      link = rb;
      if (sa > sb) begin
        keep = rb;
        link = ra;
      end
      parent_of[next_ver][keep] = sa + sb;
      parent_of[next_ver][link] = keep;
    end
    r.version_written = next_ver[VER_OUT_W-1:0];
    next_ver++;
    return r;
  endfunction

  // Command driver.
  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   burst_left = 0;
  bit   burst_fast = 1'b0;

  function automatic int draw_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 60);
      burst_fast = ($urandom_range(0, 2) == 0);
    end
    burst_left--;
    return burst_fast ? 0 : $urandom_range(0, 15);
  endfunction

  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      result_q.push_back(apply_word(in_ch.data));
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
  end

  always @(negedge clk) begin
    logic nv;
    nv = in_ch.valid && !in_taken;
    if (!nv && rst_n) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (cmd_q.size() > 0) begin
        in_ch.data <= cmd_q.pop_front();
        nv = 1'b1;
        in_gap = draw_gap();
      end
    end
    in_ch.valid <= nv;
  end

  // Result monitor.
  logic out_taken = 1'b0;
  int   out_stall = 0;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    puf_out_t got, want;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", got);
      end else begin
        want = result_q.pop_front();
        if (got.same_set !== want.same_set || got.is_answer !== want.is_answer ||
            got.version_written !== want.version_written ||
            got.out_of_room !== want.out_of_room) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_taken) out_stall = draw_gap();
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted word.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_word(logic cmd, int src, int a, int b);
    puf_in_t w;
    w.command = cmd;
    w.source_version = src[IDX_W-1:0];
    w.elem_a = a[IDX_W-1:0];
    w.elem_b = b[IDX_W-1:0];
    cmd_q.push_back(w);
    if (gen_ver < N_VER) gen_ver++;
  endtask

  task automatic push_random(int count, int n);
    int src, a, b, hi;
    for (int k = 0; k < count; k++) begin
      hi = (gen_ver > N_VER) ? N_VER : gen_ver;
      case ($urandom_range(0, 9))
        0: src = $urandom_range(0, N_VER - 1);
        1, 2: src = $urandom_range(0, hi - 1);
        default: src = $urandom_range((hi > 8) ? hi - 8 : 0, hi - 1);
      endcase
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, N_ELEM - 1) : $urandom_range(0, n - 1);
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, N_ELEM - 1) : $urandom_range(0, n - 1);
      push_word(($urandom_range(0, 2) == 0) ? CMD_QUERY : CMD_UNITE, src, a, b);
    end
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_ch.valid || result_q.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.element_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    load_count(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    gen_ver = 1;
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.element_count = '0;
    load_count(CNT_W'(RST_ELEM_COUNT));
    gen_ver = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words on the reset count of 1024 elements.
    push_word(CMD_UNITE, 0, 0, 1023);
    push_word(CMD_QUERY, 1, 1023, 0);
    push_word(CMD_QUERY, 0, 0, 1023);
    push_word(CMD_UNITE, 1, 1023, 0);
    push_word(CMD_UNITE, 1, 5, 6);
    push_word(CMD_UNITE, 5, 7, 5);
    push_word(CMD_QUERY, 6, 7, 6);
    push_word(CMD_UNITE, 6, 0, 6);
    push_word(CMD_QUERY, 8, 1023, 7);
    push_word(CMD_QUERY, 1023, 0, 1023);
    push_word(CMD_UNITE, 1000, 512, 511);
    push_word(CMD_QUERY, 11, 512, 511);
    push_random(100, 1024);
    drain();

    write_count(11'd5);
    push_word(CMD_UNITE, 0, 1023, 0);
    push_word(CMD_QUERY, 1, 4, 0);
    push_word(CMD_UNITE, 1, 700, 2);
    push_word(CMD_QUERY, 3, 2, 1023);
    push_random(40, 5);
    drain();

    write_count(11'd0);
    push_word(CMD_UNITE, 0, 0, 1023);
    push_word(CMD_QUERY, 1, 512, 0);
    push_random(15, 1);
    drain();

    write_count(11'd3);
    push_random(300, 3);
    drain();

    write_count(11'd2047);
    push_random(80, 1024);
    drain();

    write_count(11'd37);
    push_random(80, 37);
    drain();

    write_count(11'd1024);
    push_random(20, 1024);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
